// ===== src/gn2d_pkg.sv =====
// shared constants and types for the 2d gradient noise pipeline
package gn2d_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int ANGLE_BITS_DEF    = 10;
    localparam int OUT_FRAC_BITS_DEF = 15;

    // register stages from input transaction to output register
    localparam int NUM_STAGES = 17;

    localparam int T_W    = 24;  // cell fraction, Q24
    localparam int W_W    = 25;  // blend weight, Q24, unsigned
    localparam int S_W    = 17;  // quarter sine magnitude, Q15
    localparam int G_W    = 18;  // signed gradient component
    localparam int D_W    = 25;  // signed corner offset
    localparam int PROD_W = 43;  // offset times gradient
    localparam int DOT_W  = 34;  // dot product, Q30
    localparam int IX_W   = 36;  // first blend result

    localparam logic [31:0] HASH_M1 = 32'd3284157443;
    localparam logic [31:0] HASH_M2 = 32'd1911520717;
    localparam logic [31:0] HASH_M3 = 32'd2048419325;

    localparam logic [30:0] PI_Q29        = 31'd1686629713;
    localparam logic [29:0] TWO_PI_M5_Q29 = 30'd688904866;
    localparam logic [26:0] PI_M3_Q29     = 27'd76016977;

    localparam logic signed [15:0] NOISE_MAX = 16'sh7fff;
    localparam logic signed [15:0] NOISE_MIN = -16'sh8000;

    typedef logic [31:0] word_t;
    typedef logic signed [G_W-1:0] grad_t;

endpackage

// ===== src/gn2d_in_if.sv =====
// input channel: one point per transaction
interface gn2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ===== src/gn2d_out_if.sv =====
// output channel: one noise value per transaction
interface gn2d_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise;

    modport source (output valid, output noise, input ready);
    modport sink   (input valid, input noise, output ready);
endinterface

// ===== src/gn2d_hash.sv =====
// three-stage multiply, rotate and xor hash of the four cell corners
module gn2d_hash (
    input  logic              clk,
    input  logic [2:0]        en,
    input  gn2d_pkg::word_t   x0,
    input  gn2d_pkg::word_t   x1,
    input  gn2d_pkg::word_t   y0,
    input  gn2d_pkg::word_t   y1,
    output gn2d_pkg::word_t   hash [4]
);

    gn2d_pkg::word_t ax_reg [2];
    gn2d_pkg::word_t y0_reg;
    gn2d_pkg::word_t y1_reg;
    gn2d_pkg::word_t a_reg  [4];
    gn2d_pkg::word_t b_reg  [4];
    gn2d_pkg::word_t h_reg  [4];

    function automatic gn2d_pkg::word_t rot16(input gn2d_pkg::word_t v);
        return {v[15:0], v[31:16]};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ax_reg[0] <= x0 * gn2d_pkg::HASH_M1;
            ax_reg[1] <= x1 * gn2d_pkg::HASH_M1;
            y0_reg    <= y0;
            y1_reg    <= y1;
        end
        if (en[1])
        begin
            for (int c = 0; c < 4; c++)
            begin
                // corner c: bit 0 picks the x corner, bit 1 the y corner
                a_reg[c] <= ax_reg[c % 2];
                b_reg[c] <= (((c / 2) != 0 ? y1_reg : y0_reg) ^ rot16(ax_reg[c % 2]))
                            * gn2d_pkg::HASH_M2;
            end
        end
        if (en[2])
        begin
            for (int c = 0; c < 4; c++)
            begin
                h_reg[c] <= (a_reg[c] ^ rot16(b_reg[c])) * gn2d_pkg::HASH_M3;
            end
        end
    end

    assign hash = h_reg;

endmodule

// ===== src/gn2d_grad.sv =====
// four-stage polynomial sine and cosine of the hashed angle, quadrant mapping
module gn2d_grad #(
    parameter int ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic [3:0]        en,
    input  gn2d_pkg::word_t   hash,
    output gn2d_pkg::grad_t   gx,
    output gn2d_pkg::grad_t   gy
);

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [30:0] ONE_Q30    = 31'd1 << 30;

    gn2d_pkg::word_t phase;
    logic [30:0]     xs [2];

    logic [30:0] x5_reg  [2];
    logic [30:0] sq5_reg [2];
    logic [30:0] x6_reg  [2];
    logic [30:0] sq6_reg [2];
    logic [26:0] t6_reg  [2];
    logic [30:0] x7_reg  [2];
    logic [29:0] v7_reg  [2];
    logic [gn2d_pkg::S_W-1:0] s8_reg [2];
    logic [1:0]  quad_reg [4];

    gn2d_pkg::grad_t sa;
    gn2d_pkg::grad_t sb;

    always_comb
    begin
        phase = hash & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
        xs[0] = {1'b0, phase[29:0]};
        xs[1] = ONE_Q30 - {1'b0, phase[29:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            quad_reg[0] <= hash[31:30];
            for (int i = 0; i < 2; i++)
            begin
                x5_reg[i]  <= xs[i];
                sq5_reg[i] <= 31'((62'(xs[i]) * 62'(xs[i])) >> 30);
            end
        end
        if (en[1])
        begin
            quad_reg[1] <= quad_reg[0];
            for (int i = 0; i < 2; i++)
            begin
                x6_reg[i]  <= x5_reg[i];
                sq6_reg[i] <= sq5_reg[i];
                t6_reg[i]  <= 27'((58'(sq5_reg[i]) * 58'(gn2d_pkg::PI_M3_Q29)) >> 30);
            end
        end
        if (en[2])
        begin
            quad_reg[2] <= quad_reg[1];
            for (int i = 0; i < 2; i++)
            begin
                x7_reg[i] <= x6_reg[i];
                v7_reg[i] <= 30'((61'(sq6_reg[i])
                             * 61'(gn2d_pkg::TWO_PI_M5_Q29 - 30'(t6_reg[i]))) >> 30);
            end
        end
        if (en[3])
        begin
            quad_reg[3] <= quad_reg[2];
            for (int i = 0; i < 2; i++)
            begin
                s8_reg[i] <= gn2d_pkg::S_W'((62'(x7_reg[i])
                             * 62'(gn2d_pkg::PI_Q29 - 31'(v7_reg[i]))) >> 45);
            end
        end
    end

    // sa is the sine of the quarter-turn remainder, sb its cosine
    always_comb
    begin
        sa = $signed({1'b0, s8_reg[0]});
        sb = $signed({1'b0, s8_reg[1]});
        case (quad_reg[3])
            QUAD_FIRST:
            begin
                gx = sb;
                gy = sa;
            end
            QUAD_SECOND:
            begin
                gx = -sa;
                gy = sb;
            end
            QUAD_THIRD:
            begin
                gx = -sb;
                gy = -sa;
            end
            default:
            begin
                gx = sa;
                gy = -sb;
            end
        endcase
    end

endmodule

// ===== src/gn2d_smooth.sv =====
// three-stage smootherstep weight 6t^5 - 15t^4 + 10t^3 in Q24
module gn2d_smooth (
    input  logic                       clk,
    input  logic [2:0]                 en,
    input  logic [gn2d_pkg::T_W-1:0]   t,
    output logic [gn2d_pkg::W_W-1:0]   w
);

    localparam logic [27:0] FIFTEEN_Q24 = 28'd251658240;
    localparam logic [27:0] TEN_Q24     = 28'd167772160;

    logic [27:0] m;
    logic [27:0] tm_reg;
    logic [23:0] t2_reg;
    logic [23:0] t_reg;
    logic [27:0] r_reg;
    logic [23:0] t3_reg;
    logic [gn2d_pkg::W_W-1:0] w_reg;

    // 6t as two shifted copies
    assign m = FIFTEEN_Q24 - (28'({t, 2'b00}) + 28'({t, 1'b0}));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tm_reg <= 28'((52'(t) * 52'(m)) >> 24);
            t2_reg <= 24'((48'(t) * 48'(t)) >> 24);
            t_reg  <= t;
        end
        if (en[1])
        begin
            r_reg  <= TEN_Q24 - tm_reg;
            t3_reg <= 24'((48'(t2_reg) * 48'(t_reg)) >> 24);
        end
        if (en[2])
        begin
            w_reg <= gn2d_pkg::W_W'((52'(t3_reg) * 52'(r_reg)) >> 24);
        end
    end

    assign w = w_reg;

endmodule

// ===== src/gradient_noise_2d.sv =====
// top level: 2d gradient noise pipeline, Q16.16 point in, Q1.15 noise out
//
// sample channel takes one (x_coord, y_coord) point per transaction, result
// channel gives one saturated noise value per transaction, in input order.
// the work runs through 17 register stages: corner decode, three hash
// multiplies, four stages of the sine polynomial, gradient products, dot
// sums, and two rounds of subtract / multiply / add for the x and y blends,
// then the saturating output register. throughput is one point per cycle
// while the receiver keeps ready high; the longest path is one 32x32 hash
// multiply or one blend multiply per stage.
// every stage carries a valid bit and loads only when it is empty or its
// successor moves, so a stalled receiver holds the result in the output
// register while bubbles in earlier stages still fill; sample.ready drops
// only once every stage holds a point.
// reset clears all valid bits; the block can take a point as soon as
// reset is released.
module gradient_noise_2d #(
    parameter int FRAC_BITS     = gn2d_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS    = gn2d_pkg::ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = gn2d_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    gn2d_in_if.sink           sample,
    gn2d_out_if.source        result
);

    localparam int NS = gn2d_pkg::NUM_STAGES;
    localparam int T_W = gn2d_pkg::T_W;
    localparam int W_W = gn2d_pkg::W_W;
    localparam int D_W = gn2d_pkg::D_W;
    localparam int PROD_W = gn2d_pkg::PROD_W;
    localparam int DOT_W = gn2d_pkg::DOT_W;
    localparam int IX_W = gn2d_pkg::IX_W;
    localparam int DIF_W = DOT_W + 1;
    localparam int PR_W = DIF_W + W_W + 1;
    localparam int DIF2_W = IX_W + 1;
    localparam int PR2_W = DIF2_W + W_W + 1;
    localparam logic signed [D_W-1:0] ONE_Q24 = D_W'(1) << 24;

    logic [NS:1]   vld_reg;
    logic [NS:1]   en;

    // stage 1 decode
    gn2d_pkg::word_t x0_in, y0_in;
    gn2d_pkg::word_t x0_reg, x1_reg, y0_reg, y1_reg;
    logic [T_W-1:0] tx_reg [1:8];
    logic [T_W-1:0] ty_reg [1:8];
    logic [W_W-1:0] wx_reg [5:11];
    logic [W_W-1:0] wy_reg [5:14];
    logic [W_W-1:0] wx_out, wy_out;

    gn2d_pkg::word_t hash [4];
    gn2d_pkg::grad_t gx [4];
    gn2d_pkg::grad_t gy [4];

    logic signed [D_W-1:0]    dx [4];
    logic signed [D_W-1:0]    dy [4];
    logic signed [PROD_W-1:0] px_reg [4];
    logic signed [PROD_W-1:0] py_reg [4];
    logic signed [DOT_W-1:0]  dot_reg [4];
    logic signed [DIF_W-1:0]  dif_reg [2];
    logic signed [DOT_W-1:0]  a11_reg [2];
    logic signed [PR_W-1:0]   pr_reg  [2];
    logic signed [DOT_W-1:0]  a12_reg [2];
    logic signed [IX_W-1:0]   ix_reg  [2];
    logic signed [DIF2_W-1:0] d2_reg;
    logic signed [IX_W-1:0]   ix14_reg;
    logic signed [PR2_W-1:0]  p2_reg;
    logic signed [IX_W-1:0]   ix15_reg;
    logic signed [DIF2_W-1:0] v_reg;
    logic signed [DIF2_W-1:0] v_sh;
    logic signed [15:0]       noise_next;
    logic signed [15:0]       noise_reg;

    // a stage loads when it is empty or everything after it moves
    for (genvar k = 1; k <= NS; k++)
    begin : g_en
        assign en[k] = result.ready | ~(&vld_reg[NS:k]);
    end

    assign sample.ready = en[1];
    assign result.valid = vld_reg[NS];
    assign result.noise = noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= sample.valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign x0_in = sample.x_coord >>> FRAC_BITS;
    assign y0_in = sample.y_coord >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x0_reg    <= x0_in;
            x1_reg    <= x0_in + 32'd1;
            y0_reg    <= y0_in;
            y1_reg    <= y0_in + 32'd1;
            tx_reg[1] <= T_W'(32'(sample.x_coord[FRAC_BITS-1:0]) << (T_W - FRAC_BITS));
            ty_reg[1] <= T_W'(32'(sample.y_coord[FRAC_BITS-1:0]) << (T_W - FRAC_BITS));
        end
        for (int k = 2; k <= 8; k++)
        begin
            if (en[k])
            begin
                tx_reg[k] <= tx_reg[k-1];
                ty_reg[k] <= ty_reg[k-1];
            end
        end
        if (en[5])
        begin
            wx_reg[5] <= wx_out;
            wy_reg[5] <= wy_out;
        end
        for (int k = 6; k <= 14; k++)
        begin
            if (en[k])
            begin
                wy_reg[k] <= wy_reg[k-1];
                if (k <= 11)
                begin
                    wx_reg[k] <= wx_reg[k-1];
                end
            end
        end
    end

    gn2d_hash u_hash (
        .clk  (clk),
        .en   (en[4:2]),
        .x0   (x0_reg),
        .x1   (x1_reg),
        .y0   (y0_reg),
        .y1   (y1_reg),
        .hash (hash)
    );

    gn2d_smooth u_smooth_x (
        .clk (clk),
        .en  (en[4:2]),
        .t   (tx_reg[1]),
        .w   (wx_out)
    );

    gn2d_smooth u_smooth_y (
        .clk (clk),
        .en  (en[4:2]),
        .t   (ty_reg[1]),
        .w   (wy_out)
    );

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        gn2d_grad #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_grad (
            .clk  (clk),
            .en   (en[8:5]),
            .hash (hash[c]),
            .gx   (gx[c]),
            .gy   (gy[c])
        );

        // far corners see the offset minus one
        if (c % 2 == 1)
        begin : g_xfar
            assign dx[c] = $signed({1'b0, tx_reg[8]}) - ONE_Q24;
        end
        else
        begin : g_xnear
            assign dx[c] = $signed({1'b0, tx_reg[8]});
        end
        if (c / 2 == 1)
        begin : g_yfar
            assign dy[c] = $signed({1'b0, ty_reg[8]}) - ONE_Q24;
        end
        else
        begin : g_ynear
            assign dy[c] = $signed({1'b0, ty_reg[8]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            for (int c = 0; c < 4; c++)
            begin
                px_reg[c] <= PROD_W'(dx[c]) * PROD_W'(gx[c]);
                py_reg[c] <= PROD_W'(dy[c]) * PROD_W'(gy[c]);
            end
        end
        if (en[10])
        begin
            for (int c = 0; c < 4; c++)
            begin
                dot_reg[c] <= DOT_W'((45'(px_reg[c]) + 45'(py_reg[c])) >>> 9);
            end
        end
        if (en[11])
        begin
            for (int r = 0; r < 2; r++)
            begin
                dif_reg[r] <= DIF_W'(dot_reg[2*r+1]) - DIF_W'(dot_reg[2*r]);
                a11_reg[r] <= dot_reg[2*r];
            end
        end
        if (en[12])
        begin
            for (int r = 0; r < 2; r++)
            begin
                pr_reg[r]  <= PR_W'(dif_reg[r]) * PR_W'($signed({1'b0, wx_reg[11]}));
                a12_reg[r] <= a11_reg[r];
            end
        end
        if (en[13])
        begin
            for (int r = 0; r < 2; r++)
            begin
                ix_reg[r] <= IX_W'(a12_reg[r]) + IX_W'(pr_reg[r] >>> 24);
            end
        end
        if (en[14])
        begin
            d2_reg   <= DIF2_W'(ix_reg[1]) - DIF2_W'(ix_reg[0]);
            ix14_reg <= ix_reg[0];
        end
        if (en[15])
        begin
            p2_reg   <= PR2_W'(d2_reg) * PR2_W'($signed({1'b0, wy_reg[14]}));
            ix15_reg <= ix14_reg;
        end
        if (en[16])
        begin
            v_reg <= DIF2_W'(ix15_reg) + DIF2_W'(p2_reg >>> 24);
        end
        if (en[17])
        begin
            noise_reg <= noise_next;
        end
    end

    always_comb
    begin
        v_sh = v_reg >>> (30 - OUT_FRAC_BITS);
        if (v_sh > DIF2_W'(gn2d_pkg::NOISE_MAX))
        begin
            noise_next = gn2d_pkg::NOISE_MAX;
        end
        else if (v_sh < DIF2_W'(gn2d_pkg::NOISE_MIN))
        begin
            noise_next = gn2d_pkg::NOISE_MIN;
        end
        else
        begin
            noise_next = 16'(v_sh);
        end
    end

endmodule

// ===== src/gn2d_checker.sv =====
// port-level checks on the noise pipeline, bound to the top level
module gn2d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] noise
);

    localparam int NS = gn2d_pkg::NUM_STAGES;

    logic [4:0] count_reg;
    logic [4:0] count_next;

    // points taken but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            count_next = count_next + 5'd1;
        end
        if (out_valid && out_ready)
        begin
            count_next = count_next - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise))
        else $error("stalled result transaction changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 5'd0)
        else $error("result transaction with no point in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'(NS))
        else $error("more points in flight than pipeline stages");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && count_reg == 5'(NS) |-> !in_ready)
        else $error("full stalled pipeline still takes a transaction");

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .noise     (result.noise)
);

// ===== tb/gn2d_checker.sv =====
// checker: watches both channels, predicts the noise value and compares
`timescale 1ns / 1ps
module gn2d_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    gn2d_in_if.sink     sample,
    gn2d_out_if.sink    result,
    output int          fail_count,
    output int          pending
);

    localparam int FB  = gn2d_pkg::FRAC_BITS_DEF;
    localparam int AB  = gn2d_pkg::ANGLE_BITS_DEF;
    localparam int OFB = gn2d_pkg::OUT_FRAC_BITS_DEF;

    logic signed [15:0] noise_q[$];
    int                 mismatches;

    function automatic logic [31:0] rot16(logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic logic [31:0] hash_corner(logic [31:0] cx, logic [31:0] cy);
        logic [31:0] a;
        logic [31:0] b;
        a = cx * gn2d_pkg::HASH_M1;
        b = cy ^ rot16(a);
        b = b * gn2d_pkg::HASH_M2;
        a = a ^ rot16(b);
        return a * gn2d_pkg::HASH_M3;
    endfunction

    // sin(x * pi/2), x and result in Q30
    function automatic logic [63:0] sine_q30(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] v;
        x2 = (x * x) >> 30;
        t  = (x2 * 64'(gn2d_pkg::PI_M3_Q29)) >> 30;
        u  = 64'(gn2d_pkg::TWO_PI_M5_Q29) - t;
        v  = (x2 * u) >> 30;
        return (x * (64'(gn2d_pkg::PI_Q29) - v)) >> 30;
    endfunction

    function automatic logic signed [63:0] dot_corner(logic [31:0] cx, logic [31:0] cy,
                                                     logic signed [63:0] dx,
                                                     logic signed [63:0] dy);
        logic [31:0]        h;
        logic [31:0]        phase;
        logic [63:0]        r;
        logic signed [63:0] s0;
        logic signed [63:0] s1;
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        h     = hash_corner(cx, cy);
        phase = h & ~((32'd1 << (32 - AB)) - 32'd1);
        r     = 64'(phase[29:0]);
        s0    = $signed(sine_q30(r) >> 15);
        s1    = $signed(sine_q30((64'd1 << 30) - r) >> 15);
        case (phase[31:30])
            2'd0: begin gx = s1;  gy = s0;  end
            2'd1: begin gx = -s0; gy = s1;  end
            2'd2: begin gx = -s1; gy = -s0; end
            default: begin gx = s0; gy = -s1; end
        endcase
        return (dx * gx + dy * gy) >>> 9;
    endfunction

    function automatic logic signed [63:0] smootherstep(logic [63:0] t);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] t3;
        m  = (64'd15 << 24) - 64'd6 * t;
        r  = (64'd10 << 24) - ((t * m) >> 24);
        t3 = (((t * t) >> 24) * t) >> 24;
        return $signed((t3 * r) >> 24);
    endfunction

    function automatic logic signed [63:0] blend(logic signed [63:0] a0,
                                                logic signed [63:0] a1,
                                                logic signed [63:0] w);
        return a0 + (((a1 - a0) * w) >>> 24);
    endfunction

    function automatic logic signed [15:0] predict_noise(logic [31:0] xu, logic [31:0] yu);
        logic [31:0]        x0;
        logic [31:0]        y0;
        logic signed [63:0] tx;
        logic signed [63:0] ty;
        logic signed [63:0] one;
        logic signed [63:0] wx;
        logic signed [63:0] wy;
        logic signed [63:0] ix0;
        logic signed [63:0] ix1;
        logic signed [63:0] v;
        one = 64'sd1 <<< 24;
        x0  = $unsigned($signed(xu) >>> FB);
        y0  = $unsigned($signed(yu) >>> FB);
        tx  = 64'(xu[FB-1:0]) << (24 - FB);
        ty  = 64'(yu[FB-1:0]) << (24 - FB);
        wx  = smootherstep(tx);
        wy  = smootherstep(ty);
        ix0 = blend(dot_corner(x0, y0, tx, ty), dot_corner(x0 + 1, y0, tx - one, ty), wx);
        ix1 = blend(dot_corner(x0, y0 + 1, tx, ty - one),
                    dot_corner(x0 + 1, y0 + 1, tx - one, ty - one), wx);
        v = blend(ix0, ix1, wy) >>> (30 - OFB);
        if (v > 64'sd32767)
            v = 64'sd32767;
        if (v < -64'sd32768)
            v = -64'sd32768;
        return v[15:0];
    endfunction

    assign pending = noise_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            mismatches = 0;
            noise_q.delete();
        end
        else
        begin
            if (sample.valid && sample.ready)
                noise_q.push_back(predict_noise(sample.x_coord, sample.y_coord));
            if (result.valid && result.ready)
            begin
                if (noise_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected noise transaction: %0d", result.noise);
                end
                else if (noise_q[0] !== result.noise)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d actual %0d",
                                 noise_q[0], result.noise);
                    void'(noise_q.pop_front());
                end
                else
                    void'(noise_q.pop_front());
            end
            fail_count <= mismatches;
        end
    end
endmodule

// ===== tb/tb.sv =====
// testbench top: drives points into the noise pipeline and gives the verdict
`timescale 1ns / 1ps
module tb;

    localparam int RANDOM_POINTS = 1800;
    localparam int IDLE_LIMIT    = 2000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    gn2d_in_if  sample();
    gn2d_out_if result();

    gradient_noise_2d DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    gn2d_scoreboard checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample.sink),
        .result     (result.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall pattern: long open stretches, random stalls, blocked runs
    initial
    begin
        int mode;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40))
            begin
                @(posedge clk);
                case (mode)
                    0: result.ready <= 1'b1;
                    1: result.ready <= ($urandom_range(0, 3) != 0);
                    2: result.ready <= 1'($urandom_range(0, 1));
                    default: result.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready) || pending == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        sample.valid   <= 1'b1;
        sample.x_coord <= x;
        sample.y_coord <= y;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        sample.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return {16'($urandom_range(0, 7) - 4), 16'($urandom())};
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return {16'($urandom()), $urandom_range(0, 1) ? 16'hffff : 16'h0000};
            default: return {16'($urandom()), 16'($urandom())};
        endcase
    endfunction

    initial
    begin
        logic [31:0] edge_vals[8];
        int          burst;
        edge_vals = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h0000_ffff, 32'h0001_0000, 32'h7fff_0000, 32'hffff_0000};
        idle_cycles    = 0;
        rst_n          = 1'b0;
        sample.valid   = 1'b0;
        sample.x_coord = '0;
        sample.y_coord = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners of the range, cell borders, and the wrap of the far corner
        foreach (edge_vals[i])
            send_point(edge_vals[i], edge_vals[(i + 3) % 8]);
        foreach (edge_vals[i])
            send_point(edge_vals[i], edge_vals[i]);
        send_point(32'h0000_8000, 32'h0000_8000);
        send_point(32'h8000_8000, 32'h7fff_8000);
        send_point(32'h5555_5555, 32'haaaa_aaaa);
        send_point(32'haaaa_aaaa, 32'h5555_5555);

        // hold off until the pipeline has drained
        sample.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_POINTS; )
        begin
            burst = $urandom_range(1, 60);
            for (int k = 0; k < burst && n < RANDOM_POINTS; k++, n++)
                send_point(random_coord(), random_coord());
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 20));
        end
        sample.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (gn2d_pkg::NUM_STAGES + 4) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
